>>> design/lph_pkg.sv
`default_nettype none
package lph_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int KEY_W = 31;
	localparam int OP_W = 3;
	localparam int STATUS_W = 2;
	localparam int MARK_W = 2;

	localparam logic [31:0] HASH_MULT = 32'h9E3779B9;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
	localparam logic [OP_W-1:0] OP_ERASE = 3'd2;
	localparam logic [OP_W-1:0] OP_FIRST = 3'd3;
	localparam logic [OP_W-1:0] OP_NEXT = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_LIVE = 2'd1;
	localparam logic [MARK_W-1:0] MARK_TOMB = 2'd2;

	typedef struct packed {
		logic in_rdy;
		logic clr;
		logic mul1;
		logic mul2;
		logic home;
		logic scan_first;
		logic scan_next;
		logic step;
		logic wr_ins;
		logic wr_tomb;
		logic ok_ins;
		logic ok_rd;
		logic fail;
		logic [STATUS_W-1:0] fail_code;
		logic cur_set;
		logic live_inc;
		logic live_dec;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_fire;
		logic clr_last;
		logic [OP_W-1:0] op;
		logic [MARK_W-1:0] mark;
		logic key_match;
		logic n_done;
		logic pos_end;
		logic cur_valid;
		logic out_free;
	} ctl_sts_t;

endpackage
`default_nettype wire

>>> design/lph_ifs.sv
`default_nettype none
interface lph_req_if #(parameter int VALUE_WIDTH = lph_pkg::VALUE_WIDTH_DEF);
	logic valid;
	logic ready;
	logic [lph_pkg::OP_W-1:0] op;
	logic [lph_pkg::KEY_W-1:0] key;
	logic [VALUE_WIDTH-1:0] value;
	modport source (output valid, op, key, value, input ready);
	modport sink (input valid, op, key, value, output ready);
endinterface

interface lph_rsp_if #(
	parameter int TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = lph_pkg::VALUE_WIDTH_DEF
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	logic valid;
	logic ready;
	logic [lph_pkg::STATUS_W-1:0] status;
	logic [IW-1:0] slot_index;
	logic [lph_pkg::KEY_W-1:0] found_key;
	logic [VALUE_WIDTH-1:0] found_value;
	logic [CW-1:0] entry_count;
	modport source (output valid, status, slot_index, found_key, found_value, entry_count,
		input ready);
	modport sink (input valid, status, slot_index, found_key, found_value, entry_count,
		output ready);
endinterface

interface lph_cfg_if #(parameter int TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	logic valid;
	logic ready;
	logic [CW-1:0] table_capacity;
	modport source (output valid, table_capacity, input ready);
	modport sink (input valid, table_capacity, output ready);
endinterface
`default_nettype wire

>>> design/lph_ram.sv
`default_nettype none
module lph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> design/lph_ctrl.sv
`default_nettype none
module lph_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire lph_pkg::ctl_sts_t sts,
	output lph_pkg::ctl_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_MUL1, S_MUL2, S_HOME, S_READ, S_CHECK, S_DONE
	} state_t;

	state_t state_q, state_nxt;
	logic scan_op;

	assign scan_op = (sts.op == lph_pkg::OP_FIRST) || (sts.op == lph_pkg::OP_NEXT);

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				cmd.in_rdy = 1'b1;
				if (sts.in_fire) state_nxt = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_nxt = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_nxt = S_HOME;
			end
			S_HOME: begin
				case (sts.op) inside
					lph_pkg::OP_INSERT, lph_pkg::OP_SEARCH, lph_pkg::OP_ERASE: begin
						cmd.home = 1'b1;
						state_nxt = S_READ;
					end
					lph_pkg::OP_FIRST: begin
						cmd.scan_first = 1'b1;
						state_nxt = S_READ;
					end
					lph_pkg::OP_NEXT: begin
						if (sts.cur_valid) begin
							cmd.scan_next = 1'b1;
							state_nxt = S_READ;
						end else begin
							cmd.fail = 1'b1;
							cmd.fail_code = lph_pkg::ST_MISS;
							state_nxt = S_DONE;
						end
					end
					default: begin
						cmd.fail = 1'b1;
						cmd.fail_code = lph_pkg::ST_MISS;
						state_nxt = S_DONE;
					end
				endcase
			end
			S_READ: begin
				if (scan_op && sts.pos_end) begin
					cmd.fail = 1'b1;
					cmd.fail_code = lph_pkg::ST_MISS;
					state_nxt = S_DONE;
				end else if (!scan_op && sts.n_done) begin
					cmd.fail = 1'b1;
					cmd.fail_code = (sts.op == lph_pkg::OP_INSERT) ?
						lph_pkg::ST_FULL : lph_pkg::ST_MISS;
					state_nxt = S_DONE;
				end else begin
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				state_nxt = S_READ;
				case (sts.op)
					lph_pkg::OP_INSERT: begin
						if (sts.mark == lph_pkg::MARK_EMPTY) begin
							cmd.wr_ins = 1'b1;
							cmd.ok_ins = 1'b1;
							cmd.cur_set = 1'b1;
							cmd.live_inc = 1'b1;
							state_nxt = S_DONE;
						end else begin
							cmd.step = 1'b1;
						end
					end
					lph_pkg::OP_SEARCH, lph_pkg::OP_ERASE: begin
						if (sts.mark == lph_pkg::MARK_EMPTY) begin
							cmd.fail = 1'b1;
							cmd.fail_code = lph_pkg::ST_MISS;
							state_nxt = S_DONE;
						end else if (sts.mark == lph_pkg::MARK_LIVE && sts.key_match) begin
							cmd.ok_rd = 1'b1;
							if (sts.op == lph_pkg::OP_SEARCH) begin
								cmd.cur_set = 1'b1;
							end else begin
								cmd.wr_tomb = 1'b1;
								cmd.live_dec = 1'b1;
							end
							state_nxt = S_DONE;
						end else begin
							cmd.step = 1'b1;
						end
					end
					default: begin
						if (sts.mark == lph_pkg::MARK_LIVE) begin
							cmd.ok_rd = 1'b1;
							cmd.cur_set = 1'b1;
							state_nxt = S_DONE;
						end else begin
							cmd.step = 1'b1;
						end
					end
				endcase
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end
endmodule
`default_nettype wire

>>> design/lph_dp.sv
`default_nettype none
module lph_dp #(
	parameter int TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = lph_pkg::VALUE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	lph_req_if.sink req,
	lph_rsp_if.source rsp,
	lph_cfg_if.sink cfg,
	input wire lph_pkg::ctl_cmd_t cmd,
	output lph_pkg::ctl_sts_t sts
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = lph_pkg::KEY_W;
	localparam int RW = lph_pkg::MARK_W + KW + VALUE_WIDTH;
	localparam int PW = 32 + CW;

	logic [CW-1:0] cap_q, cap_eff;
	logic [lph_pkg::OP_W-1:0] op_q;
	logic [KW-1:0] key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [31:0] h1_q;
	logic [PW-1:0] prod_q;
	logic [CW-1:0] pos_q, n_q, live_q, pos_inc;
	logic [IW-1:0] cursor_q, clr_q;
	logic cur_valid_q;
	logic [lph_pkg::STATUS_W-1:0] res_status_q;
	logic [IW-1:0] res_slot_q;
	logic [KW-1:0] res_key_q;
	logic [VALUE_WIDTH-1:0] res_value_q;
	logic out_valid_q;
	logic we;
	logic [IW-1:0] waddr;
	logic [RW-1:0] wdata, rdata;
	logic [lph_pkg::MARK_W-1:0] rd_mark;
	logic [KW-1:0] rd_key;
	logic [VALUE_WIDTH-1:0] rd_value;
	logic scan_op;

	assign cfg.ready = 1'b1;
	assign req.ready = cmd.in_rdy;

	always_comb begin
		cap_eff = cap_q;
		if (cap_q == '0) cap_eff = CW'(1);
		else if (cap_q > CW'(TABLE_DEPTH)) cap_eff = CW'(TABLE_DEPTH);
	end

	assign {rd_mark, rd_key, rd_value} = rdata;
	assign scan_op = (op_q == lph_pkg::OP_FIRST) || (op_q == lph_pkg::OP_NEXT);
	assign pos_inc = pos_q + CW'(1);

	assign we = cmd.clr | cmd.wr_ins | cmd.wr_tomb;
	assign waddr = cmd.clr ? clr_q : pos_q[IW-1:0];
	always_comb begin
		if (cmd.clr) wdata = '0;
		else if (cmd.wr_ins) wdata = {lph_pkg::MARK_LIVE, key_q, value_q};
		else wdata = {lph_pkg::MARK_TOMB, rd_key, rd_value};
	end

	lph_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(pos_q[IW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		sts.in_fire = req.valid & cmd.in_rdy;
		sts.clr_last = (clr_q == IW'(TABLE_DEPTH - 1));
		sts.op = op_q;
		sts.mark = rd_mark;
		sts.key_match = (rd_key == key_q);
		sts.n_done = (n_q == cap_eff);
		sts.pos_end = (pos_q >= cap_eff);
		sts.cur_valid = cur_valid_q;
		sts.out_free = !out_valid_q | rsp.ready;
	end

	always_ff @(posedge clk) begin
		if (sts.in_fire) begin
			op_q <= req.op;
			key_q <= req.key;
			value_q <= req.value;
		end
		if (cmd.mul1) h1_q <= 32'({1'b0, key_q} * lph_pkg::HASH_MULT);
		if (cmd.mul2) prod_q <= PW'(h1_q) * PW'(cap_eff);
		if (cmd.home) begin
			pos_q <= CW'(prod_q[32 +: IW]);
			n_q <= '0;
		end else if (cmd.scan_first) begin
			pos_q <= '0;
		end else if (cmd.scan_next) begin
			pos_q <= CW'(cursor_q) + CW'(1);
		end else if (cmd.step) begin
			n_q <= n_q + CW'(1);
			if (scan_op || pos_inc < cap_eff) pos_q <= pos_inc;
			else pos_q <= '0;
		end
		if (cmd.ok_ins) begin
			res_status_q <= lph_pkg::ST_OK;
			res_slot_q <= pos_q[IW-1:0];
			res_key_q <= key_q;
			res_value_q <= value_q;
		end else if (cmd.ok_rd) begin
			res_status_q <= lph_pkg::ST_OK;
			res_slot_q <= pos_q[IW-1:0];
			res_key_q <= rd_key;
			res_value_q <= rd_value;
		end else if (cmd.fail) begin
			res_status_q <= cmd.fail_code;
			res_slot_q <= '0;
			res_key_q <= '0;
			res_value_q <= '0;
		end
		if (cmd.out_load) begin
			rsp.status <= res_status_q;
			rsp.slot_index <= res_slot_q;
			rsp.found_key <= res_key_q;
			rsp.found_value <= res_value_q;
			rsp.entry_count <= live_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CW'(TABLE_DEPTH);
			live_q <= '0;
			cursor_q <= '0;
			cur_valid_q <= 1'b0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) cap_q <= cfg.table_capacity;
			if (cmd.clr) clr_q <= clr_q + IW'(1);
			if (cmd.live_inc) live_q <= live_q + CW'(1);
			else if (cmd.live_dec && live_q != '0) live_q <= live_q - CW'(1);
			if (cmd.cur_set) begin
				cursor_q <= pos_q[IW-1:0];
				cur_valid_q <= 1'b1;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = out_valid_q;
endmodule
`default_nettype wire

>>> design/linear_probe_hash_table.sv
`default_nettype none
// channel  dir  handshake      payload
// req      in   valid/ready    op, key, value
// rsp      out  valid/ready    status, slot_index, found_key, found_value, entry_count
// cfg      in   valid/ready    table_capacity
//
// an item passes setup and hashing (S_MUL1, S_MUL2, S_HOME); each slot probed or scanned
// takes one registered ram read and one check; the result goes to the output register
// after reset every ram slot is swept to empty; req.ready stays low during the sweep
// the result waits in the output register; a new item is accepted meanwhile
// cfg is always ready
module linear_probe_hash_table #(
	parameter int TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = lph_pkg::VALUE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	lph_req_if.sink req,
	lph_rsp_if.source rsp,
	lph_cfg_if.sink cfg
);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	lph_pkg::ctl_cmd_t cmd;
	lph_pkg::ctl_sts_t sts;

	lph_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sts(sts),
		.cmd(cmd)
	);

	lph_dp #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg),
		.cmd(cmd),
		.sts(sts)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("item accepted while busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != lph_pkg::ST_OK |->
			rsp.slot_index == '0 && rsp.found_key == '0 && rsp.found_value == '0)
		else $error("failed result carries slot data");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.entry_count <= CW'(TABLE_DEPTH))
		else $error("entry count above depth");
endmodule
`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none
module tb_top;

	localparam int DEPTH = 1024;
	localparam int LIMIT = 20000000;

	typedef struct packed {
		logic [lph_pkg::OP_W-1:0] op;
		logic [lph_pkg::KEY_W-1:0] key;
		logic [31:0] value;
		logic is_cfg;
		logic wait_drain;
		logic [10:0] cap_wr;
	} req_item_t;

	typedef struct packed {
		logic [lph_pkg::STATUS_W-1:0] status;
		logic [9:0] slot_index;
		logic [lph_pkg::KEY_W-1:0] found_key;
		logic [31:0] found_value;
		logic [10:0] entry_count;
	} rsp_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	lph_req_if req ();
	lph_rsp_if rsp ();
	lph_cfg_if cfg ();

	linear_probe_hash_table u_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	logic [lph_pkg::MARK_W-1:0] mdl_mark [DEPTH];
	logic [lph_pkg::KEY_W-1:0] mdl_key [DEPTH];
	logic [31:0] mdl_val [DEPTH];
	int unsigned mdl_live;
	int unsigned mdl_cursor;
	bit mdl_cur_ok;
	int unsigned mdl_cap;

	req_item_t pending [$];
	rsp_item_t expected_rsp [$];
	int errors = 0;
	int unsigned cycles = 0;
	bit stim_done = 0;
	int drv_gap = 0;
	int rcv_gap = 0;
	int drain_hold = 0;
	bit in_acc = 0;
	bit cfg_acc = 0;
	bit out_acc = 0;
	logic [lph_pkg::KEY_W-1:0] used_keys [$];

	function automatic int unsigned home_of(logic [lph_pkg::KEY_W-1:0] k, int unsigned cap);
		logic [31:0] h;
		logic [63:0] p;
		h = 32'({1'b0, k} * lph_pkg::HASH_MULT);
		p = {32'd0, h} * 64'(cap);
		return p[63:32];
	endfunction

	function automatic int unsigned locate_key(logic [lph_pkg::KEY_W-1:0] k, int unsigned cap);
		int unsigned pos;
		pos = home_of(k, cap);
		for (int n = 0; n < cap; n++) begin
			if (mdl_mark[pos] == lph_pkg::MARK_EMPTY) return cap;
			if (mdl_mark[pos] == lph_pkg::MARK_LIVE && mdl_key[pos] == k) return pos;
			pos++;
			if (pos >= cap) pos = 0;
		end
		return cap;
	endfunction

	function automatic rsp_item_t table_apply(req_item_t it);
		rsp_item_t r;
		int unsigned cap, pos, p;
		logic [lph_pkg::STATUS_W-1:0] st;
		cap = mdl_cap;
		st = lph_pkg::ST_MISS;
		pos = cap;
		case (it.op)
			lph_pkg::OP_INSERT: begin
				p = home_of(it.key, cap);
				st = lph_pkg::ST_FULL;
				for (int n = 0; n < cap; n++) begin
					if (mdl_mark[p] == lph_pkg::MARK_EMPTY) begin
						mdl_mark[p] = lph_pkg::MARK_LIVE;
						mdl_key[p] = it.key;
						mdl_val[p] = it.value;
						mdl_live++;
						mdl_cursor = p;
						mdl_cur_ok = 1;
						st = lph_pkg::ST_OK;
						pos = p;
						break;
					end
					p++;
					if (p >= cap) p = 0;
				end
			end
			lph_pkg::OP_SEARCH: begin
				pos = locate_key(it.key, cap);
				if (pos < cap) begin
					mdl_cursor = pos;
					mdl_cur_ok = 1;
					st = lph_pkg::ST_OK;
				end
			end
			lph_pkg::OP_ERASE: begin
				pos = locate_key(it.key, cap);
				if (pos < cap) begin
					mdl_mark[pos] = lph_pkg::MARK_TOMB;
					if (mdl_live > 0) mdl_live--;
					st = lph_pkg::ST_OK;
				end
			end
			lph_pkg::OP_FIRST, lph_pkg::OP_NEXT: begin
				if (it.op == lph_pkg::OP_FIRST || mdl_cur_ok) begin
					p = (it.op == lph_pkg::OP_FIRST) ? 0 : mdl_cursor + 1;
					for (int i = p; i < cap; i++)
						if (mdl_mark[i] == lph_pkg::MARK_LIVE) begin
							pos = i;
							break;
						end
				end
				if (pos < cap) begin
					mdl_cursor = pos;
					mdl_cur_ok = 1;
					st = lph_pkg::ST_OK;
				end
			end
			default: ;
		endcase
		r.status = st;
		if (st == lph_pkg::ST_OK && pos < cap) begin
			r.slot_index = pos[9:0];
			r.found_key = mdl_key[pos];
			r.found_value = mdl_val[pos];
		end else begin
			r.slot_index = '0;
			r.found_key = '0;
			r.found_value = '0;
		end
		r.entry_count = mdl_live[10:0];
		return r;
	endfunction

	function automatic logic [lph_pkg::KEY_W-1:0] pick_key();
		if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		return lph_pkg::KEY_W'($urandom());
	endfunction

	task automatic push_op(logic [lph_pkg::OP_W-1:0] op, logic [lph_pkg::KEY_W-1:0] k,
			logic [31:0] v);
		req_item_t it;
		it = '0;
		it.op = op;
		it.key = k;
		it.value = v;
		if (op == lph_pkg::OP_INSERT) used_keys.push_back(k);
		pending.push_back(it);
	endtask

	task automatic push_cap(logic [10:0] c);
		req_item_t it;
		it = '0;
		it.is_cfg = 1;
		it.cap_wr = c;
		pending.push_back(it);
	endtask

	task automatic push_drain();
		req_item_t it;
		it = '0;
		it.wait_drain = 1;
		pending.push_back(it);
	endtask

	task automatic random_op(int keep_small);
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) push_op(lph_pkg::OP_INSERT,
			keep_small ? lph_pkg::KEY_W'($urandom_range(0, 40)) : pick_key(), $urandom());
		else if (r < 55) push_op(lph_pkg::OP_SEARCH, pick_key(), $urandom());
		else if (r < 72) push_op(lph_pkg::OP_ERASE, pick_key(), $urandom());
		else if (r < 80) push_op(lph_pkg::OP_FIRST, lph_pkg::KEY_W'($urandom()), $urandom());
		else if (r < 97) push_op(lph_pkg::OP_NEXT, lph_pkg::KEY_W'($urandom()), $urandom());
		else push_op(lph_pkg::OP_W'($urandom_range(5, 7)), lph_pkg::KEY_W'($urandom()),
			$urandom());
	endtask

	initial begin
		// directed
		push_op(lph_pkg::OP_NEXT, '0, '0);
		push_op(lph_pkg::OP_FIRST, '0, '0);
		push_op(lph_pkg::OP_SEARCH, '0, '0);
		push_op(lph_pkg::OP_INSERT, '0, '0);
		push_op(lph_pkg::OP_INSERT, '1, '1);
		push_op(lph_pkg::OP_INSERT, '0, 32'h5555_AAAA);
		push_op(lph_pkg::OP_SEARCH, '1, '0);
		push_op(lph_pkg::OP_SEARCH, '0, '0);
		push_op(lph_pkg::OP_FIRST, '0, '0);
		push_op(lph_pkg::OP_NEXT, '0, '0);
		push_op(lph_pkg::OP_NEXT, '0, '0);
		push_op(lph_pkg::OP_NEXT, '0, '0);
		push_op(lph_pkg::OP_ERASE, '0, '0);
		push_op(lph_pkg::OP_SEARCH, '0, '0);
		push_op(lph_pkg::OP_ERASE, 31'h1234, '0);
		push_op(3'd5, '1, '1);
		push_op(3'd7, '0, '0);
		push_drain();
		push_cap(11'd0);
		for (int i = 0; i < 3; i++)
			push_op(lph_pkg::OP_INSERT, lph_pkg::KEY_W'(i + 7), 32'hAAAA_5555);
		push_op(lph_pkg::OP_SEARCH, 31'd8, '0);
		push_op(lph_pkg::OP_FIRST, '0, '0);
		push_drain();
		push_cap(11'd2047);
		push_op(lph_pkg::OP_FIRST, '0, '0);
		for (int ph = 0; ph < 16; ph++) begin
			logic [10:0] c;
			int sm;
			push_drain();
			case (ph % 4)
				0: c = 11'd1;
				1: c = 11'($urandom_range(2, 12));
				2: c = 11'($urandom_range(13, 64));
				default: c = ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'($urandom_range(1025, 2047));
			endcase
			push_cap(c);
			sm = (c < 64);
			for (int i = 0; i < 100; i++) random_op(sm);
		end
		stim_done = 1;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_init
		initial mdl_mark[g] = lph_pkg::MARK_EMPTY;
	end
	initial begin
		mdl_live = 0;
		mdl_cursor = 0;
		mdl_cur_ok = 0;
		mdl_cap = 1024;
	end

	// driver
	always @(negedge clk) begin
		req_item_t it;
		logic nxt_valid, nxt_cfg;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= '0;
			req.key <= '0;
			req.value <= '0;
			cfg.valid <= 1'b0;
			cfg.table_capacity <= '0;
			rsp.ready <= 1'b0;
		end else begin
			nxt_valid = req.valid && !in_acc;
			nxt_cfg = cfg.valid && !cfg_acc;
			if (in_acc) begin
				it = '0;
				it.op = req.op;
				it.key = req.key;
				it.value = req.value;
				expected_rsp.push_back(table_apply(it));
				drv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
			end
			if (cfg_acc) begin
				mdl_cap = (cfg.table_capacity == 0) ? 1 :
					(cfg.table_capacity > DEPTH) ? DEPTH : cfg.table_capacity;
			end
			if (!nxt_valid && !nxt_cfg) begin
				if (drv_gap > 0) drv_gap = drv_gap - 1;
				else if (pending.size() > 0) begin
					if (pending[0].wait_drain) begin
						if (expected_rsp.size() == 0) begin
							if (drain_hold < 40) drain_hold++;
							else begin
								drain_hold = 0;
								void'(pending.pop_front());
							end
						end
					end else if (pending[0].is_cfg) begin
						nxt_cfg = 1'b1;
						cfg.table_capacity <= pending[0].cap_wr;
						void'(pending.pop_front());
					end else begin
						nxt_valid = 1'b1;
						req.op <= pending[0].op;
						req.key <= pending[0].key;
						req.value <= pending[0].value;
						void'(pending.pop_front());
					end
				end
			end
			req.valid <= nxt_valid;
			cfg.valid <= nxt_cfg;
			if (out_acc && $urandom_range(0, 3) == 0) rcv_gap = $urandom_range(0, 18);
			if (rcv_gap > 0) begin
				rsp.ready <= 1'b0;
				rcv_gap--;
			end else rsp.ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_item_t got, want;
		cycles++;
		in_acc = arst_n && req.valid && req.ready;
		cfg_acc = arst_n && cfg.valid && cfg.ready;
		out_acc = arst_n && rsp.valid && rsp.ready;
		if (out_acc) begin
			got = '{rsp.status, rsp.slot_index, rsp.found_key, rsp.found_value, rsp.entry_count};
			if (expected_rsp.size() == 0) begin
				$display("%0t unexpected item %h", $time, got);
				errors++;
			end else begin
				want = expected_rsp.pop_front();
				if (got.status != want.status)
					$display("%0t status exp %0d got %0d", $time, want.status, got.status);
				if (got.slot_index != want.slot_index)
					$display("%0t slot exp %0d got %0d", $time, want.slot_index, got.slot_index);
				if (got.found_key != want.found_key)
					$display("%0t key exp %h got %h", $time, want.found_key, got.found_key);
				if (got.found_value != want.found_value)
					$display("%0t value exp %h got %h", $time, want.found_value, got.found_value);
				if (got.entry_count != want.entry_count)
					$display("%0t count exp %0d got %0d", $time, want.entry_count,
						got.entry_count);
				if (got != want) errors++;
			end
		end
	end

	initial begin
		wait (arst_n);
		while (!(stim_done && pending.size() == 0 && !req.valid && expected_rsp.size() == 0)
				&& cycles < LIMIT)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (cycles >= LIMIT) begin
			$display("CHECKS FAILED");
		end else if (errors == 0 && expected_rsp.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
